### design/ptd_pkg.sv
// Shared constants, config codes and stage word types for the tone-to-density pipeline.
package ptd_pkg;

    // Curve table geometry
    localparam int unsigned CURVE_DEPTH = 1024;
    localparam int unsigned CURVE_AW    = $clog2(CURVE_DEPTH);

    // Port field widths
    localparam int unsigned RGB_W      = 8;
    localparam int unsigned CIDX_W     = 10;
    localparam int unsigned CVAL_W     = 16;
    localparam int unsigned DENS_W     = 8;
    localparam int unsigned BRIGHT_W   = 18;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 18;

    // Config register codes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Luma: weighted sum of 299/587/114, then scale by 65536/255000 rounded
    localparam int unsigned COEF_R      = 299;
    localparam int unsigned COEF_G      = 587;
    localparam int unsigned COEF_B      = 114;
    localparam int unsigned WSUM_W      = 18;
    localparam int unsigned LUMA_SHIFT  = 13;       // 65536 / 8
    localparam int unsigned LUMA_BIAS   = 15937;    // 127500 / 8, floored
    localparam int unsigned LUMA_DIV    = 31875;    // 255000 / 8
    localparam int unsigned MNUM_W      = 31;
    localparam int unsigned RECIP_SHIFT = 31;
    localparam int unsigned RECIP       = 32'((64'd1 << RECIP_SHIFT) / LUMA_DIV);
    localparam int unsigned RECIP_W     = 17;
    localparam int unsigned RPROD_W     = MNUM_W + RECIP_W;
    localparam int unsigned LUMA_W      = 17;

    // Q16 unit range
    localparam int unsigned Q16_ONE  = 65536;
    localparam int unsigned Q16_HALF = 32768;

    // Contrast product and rounding
    localparam int unsigned CPROD_W   = 35;
    localparam int unsigned CON_ROUND = Q16_HALF * 256 + 128;
    localparam int unsigned SCALE_W   = LUMA_W + CURVE_AW + 1;

    // Density rounding
    localparam int unsigned DENS_SCALE = 255;
    localparam int unsigned DENS_ROUND = 32767;
    localparam int unsigned DX_W       = 25;

    typedef struct packed {
        logic              kind;
        logic [CIDX_W-1:0] cidx;
        logic [CVAL_W-1:0] cval;
    } t_load_info;

    typedef struct packed {
        t_load_info        ld;
        logic [LUMA_W-1:0] luma;
    } t_luma_word;

    typedef struct packed {
        t_load_info          ld;
        logic [CURVE_AW-1:0] addr;
    } t_addr_word;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [GAIN_W-1:0]   gain;
        logic                invert;
    } t_cfg;

endpackage

### design/ptd_luma.sv
// Four-stage luma unit: weighted RGB sum and reciprocal division by 255000.
module ptd_luma (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ptd_pkg::t_load_info        i_ld,
    input  logic [ptd_pkg::RGB_W-1:0]  i_red,
    input  logic [ptd_pkg::RGB_W-1:0]  i_green,
    input  logic [ptd_pkg::RGB_W-1:0]  i_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output ptd_pkg::t_luma_word        o_word
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    ptd_pkg::t_load_info r_ld1, r_ld2, r_ld3, r_ld4;

    logic [ptd_pkg::WSUM_W-1:0]  r_wsum1;
    logic [ptd_pkg::MNUM_W-1:0]  r_m2, r_m3;
    logic [ptd_pkg::RPROD_W-1:0] r_prod2;
    logic [ptd_pkg::RECIP_W-1:0] r_q3;
    logic [ptd_pkg::MNUM_W-1:0]  r_t3;
    logic [ptd_pkg::LUMA_W-1:0]  r_luma4;

    logic [ptd_pkg::WSUM_W-1:0]  n_wsum;
    logic [ptd_pkg::MNUM_W-1:0]  n_m;
    logic [ptd_pkg::RECIP_W-1:0] n_q;
    logic [ptd_pkg::MNUM_W-1:0]  n_rem;
    logic [ptd_pkg::LUMA_W-1:0]  n_luma;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n_wsum = ptd_pkg::WSUM_W'(ptd_pkg::COEF_R) * ptd_pkg::WSUM_W'(i_red)
               + ptd_pkg::WSUM_W'(ptd_pkg::COEF_G) * ptd_pkg::WSUM_W'(i_green)
               + ptd_pkg::WSUM_W'(ptd_pkg::COEF_B) * ptd_pkg::WSUM_W'(i_blue);
        n_m    = (ptd_pkg::MNUM_W'(r_wsum1) << ptd_pkg::LUMA_SHIFT)
               + ptd_pkg::MNUM_W'(ptd_pkg::LUMA_BIAS);
        // Estimate is low by at most one; the remainder check fixes it
        n_q    = r_prod2[ptd_pkg::RPROD_W-1:ptd_pkg::RECIP_SHIFT];
        n_rem  = r_m3 - r_t3;
        n_luma = ptd_pkg::LUMA_W'(r_q3)
               + ptd_pkg::LUMA_W'(n_rem >= ptd_pkg::MNUM_W'(ptd_pkg::LUMA_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_ld1   <= i_ld;
            r_wsum1 <= n_wsum;
        end
        if (rdy2 && r_v1) begin
            r_ld2   <= r_ld1;
            r_m2    <= n_m;
            r_prod2 <= ptd_pkg::RPROD_W'(n_m) * ptd_pkg::RPROD_W'(ptd_pkg::RECIP);
        end
        if (rdy3 && r_v2) begin
            r_ld3 <= r_ld2;
            r_m3  <= r_m2;
            r_q3  <= n_q;
            r_t3  <= ptd_pkg::MNUM_W'(n_q) * ptd_pkg::MNUM_W'(ptd_pkg::LUMA_DIV);
        end
        if (rdy4 && r_v3) begin
            r_ld4   <= r_ld3;
            r_luma4 <= n_luma;
        end
    end

    assign o_valid     = r_v4;
    assign o_word.ld   = r_ld4;
    assign o_word.luma = r_luma4;

endmodule

### design/ptd_tone.sv
// Three-stage tone unit: brightness clamp, contrast multiply, clamp and curve address.
module ptd_tone (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptd_pkg::t_luma_word i_word,
    input  ptd_pkg::t_cfg       i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output ptd_pkg::t_addr_word o_word
);

    logic r_v5, r_v6, r_v7;
    logic rdy5, rdy6, rdy7;

    ptd_pkg::t_load_info r_ld5, r_ld6, r_ld7;

    logic        [ptd_pkg::LUMA_W-1:0]   r_bright5;
    logic signed [ptd_pkg::CPROD_W-1:0]  r_prod6;
    logic        [ptd_pkg::CURVE_AW-1:0] r_addr7;

    logic signed [ptd_pkg::BRIGHT_W:0]   n_sum;
    logic        [ptd_pkg::LUMA_W-1:0]   n_bright;
    logic signed [ptd_pkg::LUMA_W:0]     n_centered;
    logic signed [ptd_pkg::CPROD_W-1:0]  n_prod;
    logic signed [ptd_pkg::CPROD_W-1:0]  n_num;
    logic        [ptd_pkg::CPROD_W-9:0]  n_quot;
    logic        [ptd_pkg::LUMA_W-1:0]   n_con;
    logic        [ptd_pkg::SCALE_W-1:0]  n_scaled;
    logic        [ptd_pkg::CURVE_AW-1:0] n_addr;

    assign rdy7    = !r_v7 || i_ready;
    assign rdy6    = !r_v6 || rdy7;
    assign rdy5    = !r_v5 || rdy6;
    assign o_ready = rdy5;

    always_comb begin
        n_sum = $signed({2'b00, i_word.luma})
              + $signed({i_cfg.brightness[ptd_pkg::BRIGHT_W-1], i_cfg.brightness});
        if (n_sum < 0) begin
            n_bright = '0;
        end else if (n_sum > $signed((ptd_pkg::BRIGHT_W+1)'(ptd_pkg::Q16_ONE))) begin
            n_bright = ptd_pkg::LUMA_W'(ptd_pkg::Q16_ONE);
        end else begin
            n_bright = n_sum[ptd_pkg::LUMA_W-1:0];
        end

        n_centered = $signed({1'b0, r_bright5})
                   - $signed((ptd_pkg::LUMA_W+1)'(ptd_pkg::Q16_HALF));
        n_prod     = ptd_pkg::CPROD_W'(n_centered)
                   * ptd_pkg::CPROD_W'($signed({1'b0, i_cfg.gain}));

        // Round and floor-divide by 256, then clamp to the unit range
        n_num  = r_prod6 + $signed(ptd_pkg::CPROD_W'(ptd_pkg::CON_ROUND));
        n_quot = n_num[ptd_pkg::CPROD_W-1:8];
        if (n_num < 0) begin
            n_con = '0;
        end else if (n_quot > (ptd_pkg::CPROD_W-8)'(ptd_pkg::Q16_ONE)) begin
            n_con = ptd_pkg::LUMA_W'(ptd_pkg::Q16_ONE);
        end else begin
            n_con = n_quot[ptd_pkg::LUMA_W-1:0];
        end

        n_scaled = (ptd_pkg::SCALE_W'(n_con) * ptd_pkg::SCALE_W'(ptd_pkg::CURVE_DEPTH)) >> 16;
        if (n_scaled >= ptd_pkg::SCALE_W'(ptd_pkg::CURVE_DEPTH - 1)) begin
            n_addr = ptd_pkg::CURVE_AW'(ptd_pkg::CURVE_DEPTH - 1);
        end else begin
            n_addr = n_scaled[ptd_pkg::CURVE_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy5) r_v5 <= i_valid;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && i_valid) begin
            r_ld5     <= i_word.ld;
            r_bright5 <= n_bright;
        end
        if (rdy6 && r_v5) begin
            r_ld6   <= r_ld5;
            r_prod6 <= n_prod;
        end
        if (rdy7 && r_v6) begin
            r_ld7   <= r_ld6;
            r_addr7 <= n_addr;
        end
    end

    assign o_valid     = r_v7;
    assign o_word.ld   = r_ld7;
    assign o_word.addr = r_addr7;

endmodule

### design/ptd_curve.sv
// Gamma curve memory stage and density rounding output register.
module ptd_curve (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  ptd_pkg::t_addr_word        i_word,
    input  logic                       i_invert,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ptd_pkg::DENS_W-1:0] o_density
);

    logic [ptd_pkg::CVAL_W-1:0] r_curve_mem [ptd_pkg::CURVE_DEPTH];

    logic r_v8, r_kind8, r_ov;
    logic rdy8, rdy9;

    logic [ptd_pkg::CVAL_W-1:0] r_curve8;
    logic [ptd_pkg::DENS_W-1:0] r_density;

    logic                       n_load_ok;
    logic [ptd_pkg::CVAL_W-1:0] n_d;
    logic [ptd_pkg::DX_W-1:0]   n_x;
    logic [ptd_pkg::DX_W-1:0]   n_q;

    assign rdy9    = !r_ov || i_ready;
    assign rdy8    = !r_v8 || rdy9;
    assign o_ready = rdy8;

    always_comb begin
        n_load_ok = 32'(i_word.ld.cidx) < 32'(ptd_pkg::CURVE_DEPTH);
        n_d       = i_invert ? r_curve8 : ~r_curve8;
        n_x       = ptd_pkg::DX_W'(n_d) * ptd_pkg::DX_W'(ptd_pkg::DENS_SCALE)
                  + ptd_pkg::DX_W'(ptd_pkg::DENS_ROUND);
        // Divide by 65535 as (x + x/65536 + 1) / 65536
        n_q       = (n_x + (n_x >> 16) + ptd_pkg::DX_W'(1)) >> 16;
    end

    // Loads write at the same place pixels read, so table order follows word order
    always_ff @(posedge i_clk) begin
        if (rdy8 && i_valid) begin
            if (i_word.ld.kind) begin
                if (n_load_ok) begin
                    r_curve_mem[ptd_pkg::CURVE_AW'(i_word.ld.cidx)] <= i_word.ld.cval;
                end
            end else begin
                r_curve8 <= r_curve_mem[i_word.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy8) r_v8 <= i_valid;
            // drop load words here
            if (rdy9) r_ov <= r_v8 && !r_kind8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy8 && i_valid) begin
            r_kind8 <= i_word.ld.kind;
        end
        if (rdy9 && r_v8) begin
            r_density <= n_q[ptd_pkg::DENS_W-1:0];
        end
    end

    assign o_valid   = r_ov;
    assign o_density = r_density;

endmodule

### design/pixel_tone_to_density_core.sv
// A pixel word passes the luma stages, the tone stages, the curve memory stage
// and the output register in turn, and a stall can hold it in any of them.
// Throughput: one word per cycle if not stalled; nine register stages, the curve
// memory has one port that a pixel read or a table load uses once per word at
// the memory stage. Table-load words take a slot in the pipeline and give no
// result. Reset clears all stage valid bits and the config registers to their
// reset values; the curve memory is not cleared and needs loading before use.
module pixel_tone_to_density_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [ptd_pkg::RGB_W-1:0]      i_red,
    input  logic [ptd_pkg::RGB_W-1:0]      i_green,
    input  logic [ptd_pkg::RGB_W-1:0]      i_blue,
    input  logic [ptd_pkg::CIDX_W-1:0]     i_curve_index,
    input  logic [ptd_pkg::CVAL_W-1:0]     i_curve_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ptd_pkg::DENS_W-1:0]     o_density,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ptd_pkg::t_cfg       r_cfg;
    ptd_pkg::t_load_info w_ld;
    ptd_pkg::t_luma_word w_luma_word;
    ptd_pkg::t_addr_word w_addr_word;

    logic w_luma_valid, w_luma_ready;
    logic w_addr_valid, w_addr_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= '0;
            r_cfg.gain       <= ptd_pkg::GAIN_RESET;
            r_cfg.invert     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptd_pkg::CFG_BRIGHTNESS: begin
                    r_cfg.brightness <= i_cfg_data[ptd_pkg::BRIGHT_W-1:0];
                end
                ptd_pkg::CFG_CONTRAST: begin
                    r_cfg.gain <= i_cfg_data[ptd_pkg::GAIN_W-1:0];
                end
                ptd_pkg::CFG_INVERT: begin
                    r_cfg.invert <= i_cfg_data[0];
                end
                default: begin
                    // unknown index: ignore
                end
            endcase
        end
    end

    assign w_ld.kind = i_kind;
    assign w_ld.cidx = i_curve_index;
    assign w_ld.cval = i_curve_value;

    ptd_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ld    (w_ld),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_luma_valid),
        .i_ready (w_luma_ready),
        .o_word  (w_luma_word)
    );

    ptd_tone u_tone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_luma_valid),
        .o_ready (w_luma_ready),
        .i_word  (w_luma_word),
        .i_cfg   (r_cfg),
        .o_valid (w_addr_valid),
        .i_ready (w_addr_ready),
        .o_word  (w_addr_word)
    );

    ptd_curve u_curve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_addr_valid),
        .o_ready   (w_addr_ready),
        .i_word    (w_addr_word),
        .i_invert  (r_cfg.invert),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_density (o_density)
    );

endmodule

### design/ptd_checker.sv
// Port-level checker for the tone-to-density core, with its bind.
module ptd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           i_kind,
    input logic [ptd_pkg::RGB_W-1:0]      i_red,
    input logic [ptd_pkg::RGB_W-1:0]      i_green,
    input logic [ptd_pkg::RGB_W-1:0]      i_blue,
    input logic [ptd_pkg::CIDX_W-1:0]     i_curve_index,
    input logic [ptd_pkg::CVAL_W-1:0]     i_curve_value,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [ptd_pkg::DENS_W-1:0]     o_density,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [ptd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [ptd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned FLOW_LAT = 9;

    // Track pixel acceptance and uninterrupted downstream flow
    logic [FLOW_LAT-1:0] r_acc_hist;
    logic [FLOW_LAT-1:0] r_ok_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_hist <= '0;
            r_ok_hist  <= '0;
        end else begin
            r_acc_hist <= {r_acc_hist[FLOW_LAT-2:0], i_valid && o_ready && !i_kind};
            r_ok_hist  <= {r_ok_hist[FLOW_LAT-2:0], i_ready};
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_density))
        else $error("stalled result word changed or vanished");

    a_ready_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output side is ready");

    a_flow_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_ok_hist) |-> (o_valid == r_acc_hist[FLOW_LAT-1]))
        else $error("result word does not match pixel accepted nine cycles back");

endmodule

bind pixel_tone_to_density_core ptd_checker u_ptd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_kind        (i_kind),
    .i_red         (i_red),
    .i_green       (i_green),
    .i_blue        (i_blue),
    .i_curve_index (i_curve_index),
    .i_curve_value (i_curve_value),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_density     (o_density),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);

### tb/sv/pixel_tone_to_density_core_tb.sv
// Testbench for pixel_tone_to_density_core: random paced traffic checked against an in-bench density predictor.
`timescale 1ns / 1ps

module pixel_tone_to_density_core_tb;
    import ptd_pkg::*;

    localparam int LATENCY = 9;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint UNIT  = longint'(Q16_ONE);
    localparam longint HALF  = longint'(Q16_HALF);
    localparam longint DEPTH = longint'(CURVE_DEPTH);

    typedef enum logic [1:0] {RX_OPEN, RX_SKIP, RX_COIN, RX_TRICKLE} rx_pace_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_kind = KIND_PIXEL;
    logic [RGB_W-1:0]      i_red = '0;
    logic [RGB_W-1:0]      i_green = '0;
    logic [RGB_W-1:0]      i_blue = '0;
    logic [CIDX_W-1:0]     i_curve_index = '0;
    logic [CVAL_W-1:0]     i_curve_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [DENS_W-1:0]     o_density;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BRIGHTNESS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pixel_tone_to_density_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_curve_index (i_curve_index),
        .i_curve_value (i_curve_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_density     (o_density),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    class density_tracker;
        bit [CVAL_W-1:0]   curve [CURVE_DEPTH];
        bit                loaded [CURVE_DEPTH];
        longint            bright_ofs;
        longint            gain;
        bit                invert;
        logic [DENS_W-1:0] want_density [$];
        int                mismatches;

        function new();
            bright_ofs = 0;
            gain       = longint'(GAIN_RESET);
            invert     = 1'b0;
            mismatches = 0;
        endfunction

        function longint unit_clamp(longint v);
            if (v < 0)
                return 0;
            if (v > UNIT)
                return UNIT;
            return v;
        endfunction

        // Curve entry a pixel lands on under the current settings
        function int curve_slot(logic [RGB_W-1:0] r, logic [RGB_W-1:0] g,
                                logic [RGB_W-1:0] b);
            longint wsum, luma, bright, num, con, slot;
            wsum   = 299 * longint'(r) + 587 * longint'(g) + 114 * longint'(b);
            luma   = (wsum * UNIT + 127500) / 255000;
            bright = unit_clamp(luma + bright_ofs);
            num    = (bright - HALF) * gain + 128 + HALF * 256;
            con    = (num < 0) ? 0 : unit_clamp(num / 256);
            slot   = (con * DEPTH) >> 16;
            if (slot > DEPTH - 1)
                slot = DEPTH - 1;
            return int'(slot);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BRIGHTNESS: bright_ofs = longint'($signed(data[BRIGHT_W-1:0]));
                CFG_CONTRAST:   gain = longint'(data[GAIN_W-1:0]);
                CFG_INVERT:     invert = data[0];
                default: ;
            endcase
        endfunction

        function void note_word(logic kind, logic [RGB_W-1:0] r, logic [RGB_W-1:0] g,
                                logic [RGB_W-1:0] b, logic [CIDX_W-1:0] cidx,
                                logic [CVAL_W-1:0] cval);
            int     slot;
            longint d;
            if (kind == KIND_LOAD) begin
                if (cidx < CURVE_DEPTH) begin
                    curve[cidx]  = cval;
                    loaded[cidx] = 1'b1;
                end
                return;
            end
            slot = curve_slot(r, g, b);
            d = invert ? longint'(curve[slot]) : 65535 - longint'(curve[slot]);
            want_density.push_back(DENS_W'((d * 255 + 32767) / 65535));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_density(logic [DENS_W-1:0] got);
            logic [DENS_W-1:0] exp_d;
            if (want_density.size() == 0) begin
                report($sformatf("density %0d arrived with no pixel pending", got));
                return;
            end
            exp_d = want_density.pop_front();
            if (got !== exp_d)
                report($sformatf("density mismatch: expected %0d, got %0d", exp_d, got));
        endfunction

        function int close();
            if (want_density.size() != 0)
                report($sformatf("%0d densities never arrived", want_density.size()));
            mismatches += (want_density.size() > 1) ? want_density.size() - 1 : 0;
            return mismatches;
        endfunction
    endclass

    density_tracker sb;
    int             burst_left = 0;
    logic [15:0]    rx_tick = '0;
    rx_pace_t       rx_mode = RX_OPEN;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: check each accepted word and stall on a shifting pattern
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_ready)
            sb.check_density(o_density);
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick[5:0] == 6'd0)
            rx_mode <= rx_pace_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  i_ready <= 1'b1;
            RX_SKIP:  i_ready <= (rx_tick[1:0] != 2'd3);
            RX_COIN:  i_ready <= 1'($urandom_range(0, 1));
            default:  i_ready <= (rx_tick[2:0] == 3'd0);
        endcase
    end

    task automatic send_word(input logic kind, input logic [RGB_W-1:0] r,
                             input logic [RGB_W-1:0] g, input logic [RGB_W-1:0] b,
                             input logic [CIDX_W-1:0] cidx, input logic [CVAL_W-1:0] cval);
        int gap;
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_curve_index <= cidx;
        i_curve_value <= cval;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_word(kind, r, g, b, cidx, cval);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic load_entry(input logic [CIDX_W-1:0] cidx, input logic [CVAL_W-1:0] cval);
        send_word(KIND_LOAD, RGB_W'($urandom), RGB_W'($urandom), RGB_W'($urandom), cidx, cval);
    endtask

    // Load the entry a pixel will read first if it was never written
    task automatic send_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
                              input logic [RGB_W-1:0] b);
        int slot;
        slot = sb.curve_slot(r, g, b);
        if (!sb.loaded[slot])
            load_entry(CIDX_W'(slot), CVAL_W'($urandom));
        send_word(KIND_PIXEL, r, g, b, CIDX_W'($urandom), CVAL_W'($urandom));
    endtask

    function automatic logic [RGB_W-1:0] pick_tone();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return RGB_W'($urandom_range(0, 255));
    endfunction

    task automatic random_traffic(input int count);
        repeat (count) begin
            if ($urandom_range(0, 7) == 0)
                load_entry(CIDX_W'($urandom), CVAL_W'($urandom));
            else
                send_pixel(pick_tone(), pick_tone(), pick_tone());
        end
    endtask

    // Hold off until the pipeline is empty, loads included
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.want_density.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.note_config(idx, data);
    endtask

    task automatic set_config(input logic [BRIGHT_W-1:0] bright, input logic [GAIN_W-1:0] gain,
                              input logic inv, input bit poke_spare);
        logic [CFG_DATA_W-1:0] word;
        settle();
        write_reg(CFG_BRIGHTNESS, bright);
        // Upper bits of the narrow registers carry junk that must be dropped
        word = CFG_DATA_W'($urandom);
        word[GAIN_W-1:0] = gain;
        write_reg(CFG_CONTRAST, word);
        word = CFG_DATA_W'($urandom);
        word[0] = inv;
        write_reg(CFG_INVERT, word);
        if (poke_spare)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Table extremes and inner points, then black, white (saturates to last entry), primaries, greys
        load_entry(10'd0, 16'h0000);
        load_entry(CIDX_W'(CURVE_DEPTH - 1), 16'hFFFF);
        load_entry(10'd512, 16'h8000);
        load_entry(10'h155, 16'hAAAA);
        load_entry(10'h2AA, 16'h5555);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd85, 8'd85, 8'd85);
        send_pixel(8'd170, 8'd170, 8'd170);
        load_entry(CIDX_W'(CURVE_DEPTH - 1), 16'h0000);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd253, 8'd252);

        // Brightness at +1.0 and -1.0, gain zero, then the 18-bit and gain limits
        set_config(18'h10000, 16'd256, 1'b1, 1'b1);
        random_traffic(110);
        set_config(18'h30000, 16'd0, 1'b0, 1'b0);
        random_traffic(110);
        set_config(18'h1FFFF, 16'hFFFF, 1'b1, 1'b0);
        random_traffic(110);
        set_config(18'h20000, 16'hFFFF, 1'b0, 1'b1);
        random_traffic(110);

        for (int ph = 0; ph < 8; ph++) begin
            set_config(BRIGHT_W'($urandom),
                       ($urandom_range(0, 2) != 0) ? GAIN_W'($urandom_range(128, 640))
                                                  : GAIN_W'($urandom),
                       1'($urandom), ph[0]);
            random_traffic(110);
        end

        settle();
        if (sb.close() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
design/ptd_pkg.sv
design/ptd_luma.sv
design/ptd_tone.sv
design/ptd_curve.sv
design/pixel_tone_to_density_core.sv
design/ptd_checker.sv
tb/sv/pixel_tone_to_density_core_tb.sv
